// File: src/arc_pkg.sv
// Shared types, constants and helpers for the ARP receive classifier.
package arc_pkg;

  localparam int unsigned HdrLen  = 28;
  localparam int unsigned IdxW    = 5;
  localparam logic [IdxW-1:0] HDR_LEN     = IdxW'(HdrLen);
  localparam logic [IdxW-1:0] IDX_OP_HI   = IdxW'(6);
  localparam logic [IdxW-1:0] IDX_OP_LO   = IdxW'(7);
  localparam logic [IdxW-1:0] IDX_SMAC_LO = IdxW'(8);
  localparam logic [IdxW-1:0] IDX_SMAC_HI = IdxW'(13);
  localparam logic [IdxW-1:0] IDX_SIP_LO  = IdxW'(14);
  localparam logic [IdxW-1:0] IDX_SIP_HI  = IdxW'(17);
  localparam logic [IdxW-1:0] IDX_TIP_LO  = IdxW'(24);
  localparam logic [IdxW-1:0] IDX_FIX_HI  = IdxW'(5);

  localparam logic [15:0] OP_REQUEST   = 16'd1;
  localparam logic [15:0] OP_REPLY     = 16'd2;
  localparam logic [15:0] OP_RARP_LAST = 16'd4;

  typedef enum logic [2:0] {
    VERDICT_SHORT     = 3'd0,
    VERDICT_BAD_HDR   = 3'd1,
    VERDICT_REQ_LOCAL = 3'd2,
    VERDICT_REQ_OTHER = 3'd3,
    VERDICT_REPLY     = 3'd4,
    VERDICT_RARP      = 3'd5
  } verdict_e;

  typedef struct packed {
    verdict_e     verdict;
    logic         learn;
    logic [47:0]  src_mac;
    logic [31:0]  src_ip;
  } res_t;

  // Expected value of the fixed header bytes: htype 1, ptype 0x0800, hlen 6, plen 4.
  function automatic logic [7:0] hdr_byte(input logic [IdxW-1:0] idx);
    logic [7:0] val;
    unique case (idx)
      IdxW'(0): val = 8'h00;
      IdxW'(1): val = 8'h01;
      IdxW'(2): val = 8'h08;
      IdxW'(3): val = 8'h00;
      IdxW'(4): val = 8'h06;
      IdxW'(5): val = 8'h04;
      default:  val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// File: src/arp_receive_classifier.sv
// Top level of the ARP receive classifier: input register, parser, result register.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_stall_o      | data_byte_i, last_byte_i
//   out     | output    | out_valid_o / out_stall_i    | verdict_o, learn_entry_o,
//           |           |                              | sender_mac_out_o, sender_ip_out_o
//   cfg     | input     | cfg_we_i                     | cfg_data_i (local IP)
//
// One byte per cycle sustained, unless a final byte waits for room in the result register.
// Bytes pass through one input register, then the parser and compare logic,
// then the result register; only a final byte needs room in the result register.
// Reset clears the packet state, the local IP and both valid flags.
// A stalled result holds the final byte in the input register and stalls the input.
module arp_receive_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  verdict_o,
  output logic        learn_entry_o,
  output logic [47:0] sender_mac_out_o,
  output logic [31:0] sender_ip_out_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i
);
  import arc_pkg::*;

  logic        iv_q, iv_d;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [31:0] local_ip_q;
  logic        in_accept;
  logic        proc_fire;
  logic        out_ready;
  res_t        parse_res;
  res_t        out_res;

  // Non-final bytes never wait on the output side.
  assign proc_fire  = iv_q && (!last_q || out_ready);
  assign in_stall_o = iv_q && !proc_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    iv_d = iv_q;
    if (in_accept) begin
      iv_d = 1'b1;
    end else if (proc_fire) begin
      iv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q       <= 1'b0;
      local_ip_q <= '0;
    end else begin
      iv_q <= iv_d;
      if (cfg_we_i) begin
        local_ip_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  arc_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (proc_fire),
    .byte_i     (byte_q),
    .last_i     (last_q),
    .local_ip_i (local_ip_q),
    .res_o      (parse_res)
  );

  arc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (proc_fire && last_q),
    .res_i       (parse_res),
    .out_stall_i (out_stall_i),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign verdict_o        = out_res.verdict;
  assign learn_entry_o    = out_res.learn;
  assign sender_mac_out_o = out_res.src_mac;
  assign sender_ip_out_o  = out_res.src_ip;

endmodule

// File: src/arc_parser.sv
// Header capture, field check and packet classification for one byte per cycle.
module arc_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  input  logic [31:0]      local_ip_i,
  output arc_pkg::res_t    res_o
);
  import arc_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d, idx_upd;
  logic            bad_q, bad_d, bad_upd;
  logic [15:0]     op_q, op_d, op_upd;
  logic [47:0]     smac_q, smac_d, smac_upd;
  logic [31:0]     sip_q, sip_d, sip_upd;
  logic [31:0]     tip_q, tip_d, tip_upd;

  always_comb begin
    idx_upd  = idx_q;
    bad_upd  = bad_q;
    op_upd   = op_q;
    smac_upd = smac_q;
    sip_upd  = sip_q;
    tip_upd  = tip_q;
    if (fire_i && (idx_q < HDR_LEN)) begin
      if (idx_q <= IDX_FIX_HI) begin
        if (byte_i != hdr_byte(idx_q)) bad_upd = 1'b1;
      end else if (idx_q == IDX_OP_HI || idx_q == IDX_OP_LO) begin
        op_upd = {op_q[7:0], byte_i};
      end else if (idx_q >= IDX_SMAC_LO && idx_q <= IDX_SMAC_HI) begin
        smac_upd = {smac_q[39:0], byte_i};
      end else if (idx_q >= IDX_SIP_LO && idx_q <= IDX_SIP_HI) begin
        sip_upd = {sip_q[23:0], byte_i};
      end else if (idx_q >= IDX_TIP_LO) begin
        tip_upd = {tip_q[23:0], byte_i};
      end
      idx_upd = idx_q + IdxW'(1);
    end
  end

  // A finished packet returns all capture state to zero.
  always_comb begin
    if (fire_i && last_i) begin
      idx_d  = '0;
      bad_d  = 1'b0;
      op_d   = '0;
      smac_d = '0;
      sip_d  = '0;
      tip_d  = '0;
    end else begin
      idx_d  = idx_upd;
      bad_d  = bad_upd;
      op_d   = op_upd;
      smac_d = smac_upd;
      sip_d  = sip_upd;
      tip_d  = tip_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      bad_q  <= 1'b0;
      op_q   <= '0;
      smac_q <= '0;
      sip_q  <= '0;
      tip_q  <= '0;
    end else begin
      idx_q  <= idx_d;
      bad_q  <= bad_d;
      op_q   <= op_d;
      smac_q <= smac_d;
      sip_q  <= sip_d;
      tip_q  <= tip_d;
    end
  end

  // Verdict from the state as it stands after this byte.
  always_comb begin
    res_o.verdict = VERDICT_SHORT;
    res_o.learn   = 1'b0;
    priority if (idx_upd < HDR_LEN) begin
      res_o.verdict = VERDICT_SHORT;
    end else if (bad_upd || op_upd == 16'd0 || op_upd > OP_RARP_LAST) begin
      res_o.verdict = VERDICT_BAD_HDR;
    end else if (op_upd == OP_REQUEST) begin
      res_o.verdict = (tip_upd == local_ip_i) ? VERDICT_REQ_LOCAL : VERDICT_REQ_OTHER;
      res_o.learn   = 1'b1;
    end else if (op_upd == OP_REPLY) begin
      res_o.verdict = VERDICT_REPLY;
      res_o.learn   = 1'b1;
    end else begin
      res_o.verdict = VERDICT_RARP;
    end
    res_o.src_mac = res_o.learn ? smac_upd : '0;
    res_o.src_ip  = res_o.learn ? sip_upd : '0;
  end

`ifndef SYNTHESIS
  a_idx_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= HDR_LEN)
    else $error("byte index beyond header length");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i |=> idx_q == '0 && !bad_q && op_q == '0)
    else $error("packet state not cleared after final byte");

  a_idx_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(idx_q) && $stable(tip_q))
    else $error("capture state moved without a byte");
`endif

endmodule

// File: src/arc_out_reg.sv
// Result register toward the downstream side.
module arc_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  arc_pkg::res_t    res_i,
  input  logic             out_stall_i,
  output logic             ready_o,
  output logic             out_valid_o,
  output arc_pkg::res_t    res_o
);
  import arc_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_learn_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> res_q.learn == (res_q.verdict == VERDICT_REQ_LOCAL ||
                                res_q.verdict == VERDICT_REQ_OTHER ||
                                res_q.verdict == VERDICT_REPLY))
    else $error("learn flag disagrees with verdict");

  a_no_learn_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !res_q.learn |-> res_q.src_mac == '0 && res_q.src_ip == '0)
    else $error("sender fields set without learn");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ready_o)
    else $error("result loaded over an untaken item");
`endif

endmodule

// File: tb/arp_receive_classifier_test.sv
// Self-checking testbench for the ARP receive classifier: packet stimulus and checked verdicts.
module arp_receive_classifier_test;
  import arc_pkg::*;

  localparam logic [47:0] ARP_FIXED   = 48'h0001_0800_0604; // htype, ptype, hlen, plen
  localparam logic [15:0] OP_NONE     = 16'd0;
  localparam logic [15:0] OP_RARP_REQ = 16'd3;
  localparam logic [15:0] OP_BEYOND   = 16'd5;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          PHASE_BYTES = 115;

  typedef struct {
    int          len;       // bytes in the packet, last flag on the final one
    logic [15:0] op;
    int          bad_at;    // fixed header byte to corrupt, -1 for none
    bit          aim_local; // target IP set to the local address
    int          fill;      // byte value for all address fields but a local target IP, -1 for random
    bit          typed;     // verdict below is the expected one
    verdict_e    want;
  } arp_case_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  data_byte  = 8'h00;
  logic        last_byte  = 1'b0;
  logic        out_stall  = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [31:0] cfg_data   = 32'h0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  verdict;
  logic        learn_entry;
  logic [47:0] mac_out;
  logic [31:0] ip_out;

  // predictor state
  logic [31:0] my_ip;
  int unsigned pkt_pos;
  bit          hdr_err;
  logic [15:0] op_code;
  logic [47:0] s_mac;
  logic [31:0] s_ip;
  logic [31:0] t_ip;
  bit          fixed_on;
  verdict_e    fixed_verdict;
  res_t        pending_verdicts [$];

  int unsigned sent_bytes;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_go;
  bit          hold_done;
  int unsigned hold_left;
  arp_case_t   directed [$];

  always #6 clk = ~clk;

  arp_receive_classifier i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .last_byte_i      (last_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .verdict_o        (verdict),
    .learn_entry_o    (learn_entry),
    .sender_mac_out_o (mac_out),
    .sender_ip_out_o  (ip_out),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data)
  );

  function automatic void clear_packet();
    pkt_pos = 0;
    hdr_err = 1'b0;
    op_code = '0;
    s_mac   = '0;
    s_ip    = '0;
    t_ip    = '0;
  endfunction

  // Consumes one accepted item; on the final byte queues the expected verdict.
  function automatic void parse_arp_byte(input logic [7:0] b, input logic last);
    res_t r;
    sent_bytes++;
    if (pkt_pos < HdrLen) begin
      if (pkt_pos < 6) begin
        if (b != ARP_FIXED[47 - 8 * pkt_pos -: 8]) hdr_err = 1'b1;
      end else if (pkt_pos < 8) op_code = {op_code[7:0], b};
      else if (pkt_pos < 14) s_mac = {s_mac[39:0], b};
      else if (pkt_pos < 18) s_ip = {s_ip[23:0], b};
      else if (pkt_pos >= 24) t_ip = {t_ip[23:0], b};
      pkt_pos++;
    end
    if (last) begin
      r = '0;
      if (fixed_on) begin
        r.verdict = fixed_verdict;
      end else if (pkt_pos < HdrLen) begin
        r.verdict = VERDICT_SHORT;
      end else if (hdr_err || op_code < OP_REQUEST || op_code > OP_RARP_LAST) begin
        r.verdict = VERDICT_BAD_HDR;
      end else if (op_code == OP_REQUEST || op_code == OP_REPLY) begin
        if (op_code == OP_REPLY) r.verdict = VERDICT_REPLY;
        else r.verdict = (t_ip == my_ip) ? VERDICT_REQ_LOCAL : VERDICT_REQ_OTHER;
        r.learn   = 1'b1;
        r.src_mac = s_mac;
        r.src_ip  = s_ip;
      end else begin
        r.verdict = VERDICT_RARP;
      end
      pending_verdicts.push_back(r);
      clear_packet();
    end
  endfunction

  // Starts and ends at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_arp_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_arp(input arp_case_t c);
    logic [7:0]  pkt [$];
    logic [31:0] tip;
    for (int i = 0; i < 6; i++) pkt.push_back(ARP_FIXED[47 - 8 * i -: 8]);
    pkt.push_back(c.op[15:8]);
    pkt.push_back(c.op[7:0]);
    for (int i = 8; i < 24; i++) pkt.push_back(c.fill < 0 ? 8'($urandom) : 8'(c.fill));
    tip = c.aim_local ? my_ip : (c.fill < 0 ? $urandom : {4{8'(c.fill)}});
    for (int i = 0; i < 4; i++) pkt.push_back(tip[31 - 8 * i -: 8]);
    while (pkt.size() < c.len) pkt.push_back(8'($urandom));
    if (c.bad_at >= 0) pkt[c.bad_at] ^= 8'($urandom_range(1, 255));
    fixed_on      = c.typed;
    fixed_verdict = c.want;
    for (int i = 0; i < c.len; i++) send_byte(pkt[i], i == c.len - 1);
    fixed_on = 1'b0;
  endtask

  // Mostly well-formed packets with random content, some truncated, corrupt or odd.
  function automatic arp_case_t random_arp();
    arp_case_t c;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 75) c.len = HdrLen;
    else if (roll < 88) c.len = $urandom_range(HdrLen + 1, 70);
    else c.len = $urandom_range(1, HdrLen - 1);
    roll = $urandom_range(99);
    if (roll < 40) c.op = OP_REQUEST;
    else if (roll < 70) c.op = OP_REPLY;
    else if (roll < 80) c.op = $urandom_range(1) ? OP_RARP_REQ : OP_RARP_LAST;
    else c.op = 16'($urandom);
    c.bad_at    = ($urandom_range(99) < 10) ? $urandom_range(0, 5) : -1;
    c.aim_local = $urandom_range(1);
    c.fill      = ($urandom_range(19) == 0) ? ($urandom_range(1) ? 255 : 0) : -1;
    c.typed     = 1'b0;
    c.want      = VERDICT_SHORT;
    return c;
  endfunction

  // Lets all expected verdicts arrive, then waits for bytes still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_local_ip(input logic [31:0] ip);
    cfg_we   <= 1'b1;
    cfg_data <= ip;
    @(negedge clk);
    cfg_we <= 1'b0;
    my_ip = ip;
  endtask

  task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random stalls, plus one long hold-off so the block backs up
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = 150;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: verdict %0d", verdict);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", 48'(want.verdict), 48'(verdict));
        check_field("learn_entry", 48'(want.learn), 48'(learn_entry));
        check_field("sender_mac_out", want.src_mac, mac_out);
        check_field("sender_ip_out", 48'(want.src_ip), 48'(ip_out));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int unsigned first;
    clear_packet();
    my_ip         = '0;
    fixed_on      = 1'b0;
    fixed_verdict = VERDICT_SHORT;
    sent_bytes    = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_go       = 1'b0;
    hold_done     = 1'b0;
    hold_left     = 0;

    //                len  op            bad  loc fill typed verdict
    directed.push_back('{1,  OP_REQUEST,  -1, 0, -1,  1, VERDICT_SHORT});
    directed.push_back('{27, OP_REQUEST,  -1, 1, -1,  1, VERDICT_SHORT});
    directed.push_back('{20, OP_REQUEST,   0, 1, -1,  1, VERDICT_SHORT});
    directed.push_back('{28, OP_REQUEST,  -1, 1, -1,  0, VERDICT_SHORT});
    directed.push_back('{28, OP_REQUEST,  -1, 0, 0,   0, VERDICT_SHORT});
    directed.push_back('{28, OP_REPLY,    -1, 0, 255, 0, VERDICT_SHORT});
    directed.push_back('{40, OP_REPLY,    -1, 0, -1,  0, VERDICT_SHORT});
    directed.push_back('{29, OP_REQUEST,  -1, 1, 0,   0, VERDICT_SHORT});
    directed.push_back('{64, OP_REQUEST,  -1, 1, 255, 0, VERDICT_SHORT});
    directed.push_back('{28, OP_RARP_REQ, -1, 0, -1,  1, VERDICT_RARP});
    directed.push_back('{28, OP_RARP_LAST,-1, 0, -1,  1, VERDICT_RARP});
    directed.push_back('{28, OP_NONE,     -1, 0, -1,  1, VERDICT_BAD_HDR});
    directed.push_back('{28, OP_BEYOND,   -1, 0, -1,  1, VERDICT_BAD_HDR});
    directed.push_back('{28, 16'h0101,    -1, 0, -1,  1, VERDICT_BAD_HDR});
    directed.push_back('{28, 16'hffff,    -1, 0, -1,  1, VERDICT_BAD_HDR});
    for (int i = 0; i < 6; i++) directed.push_back('{28, OP_REQUEST, i, 1, -1, 1, VERDICT_BAD_HDR});
    directed.push_back('{28, OP_RARP_REQ,  2, 0, -1,  1, VERDICT_BAD_HDR});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_local_ip(32'hc0a8_0164);
    foreach (directed[i]) send_arp(directed[i]);

    // random phases: free flow with one long hold, sender idling, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: write_local_ip(32'h0000_0000);
        1: write_local_ip(32'hffff_ffff);
        default: write_local_ip($urandom);
      endcase
      send_idle_pct = (ph == 1) ? 87 : (ph == 3) ? 24 : 0;
      stall_pct     = (ph == 2) ? 87 : (ph == 3) ? 24 : 0;
      if (ph == 0) hold_go = 1'b1;
      first = sent_bytes;
      while (sent_bytes - first < PHASE_BYTES) send_arp(random_arp());
    end

    drain();
    repeat (6) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
src/arc_pkg.sv
src/arc_parser.sv
src/arc_out_reg.sv
src/arp_receive_classifier.sv
tb/arp_receive_classifier_test.sv
